/* design/console_line_editor_assert.svh */
// assertion macros shared by the line editor modules
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// property that must hold in the cycle after its trigger
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/cle_pkg.sv */
package cle_pkg;

    // default ring depth
    localparam int CLE_BUF_DEPTH = 64;

    // special characters
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_DEL  = 8'h7f;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // command codes on the input beat
    typedef enum logic [1:0] {
        CMD_RX   = 2'd0,
        CMD_READ = 2'd1,
        CMD_TX   = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd_code;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_KILL
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TX_ECHO,
        OP_STORE,
        OP_ERASE,
        OP_EMPTY,
        OP_READ_ISSUE,
        OP_READ_DONE,
        OP_KILL_START,
        OP_KILL_STEP,
        OP_KILL_END
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_kill;
        logic is_erase;
        logic is_zero;
        logic full;
        logic edit_at_commit;
        logic read_at_commit;
        logic mem_lf;
    } t_dp_status;

endpackage

/* design/cle_ctrl.sv */
module cle_ctrl
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_cmd,
    input  t_dp_status i_status,
    output t_dp_cmd    o_dp_cmd,
    output logic       busy
);

    `include "console_line_editor_assert.svh"

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   accept;
    logic   kill_cont;

    assign accept    = start && (r_state == ST_IDLE);
    assign kill_cont = !i_status.edit_at_commit && !i_status.mem_lf;
    assign busy      = (r_state != ST_IDLE);

    // state and pending erase flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // command decode
    always_comb begin
        o_dp_cmd.op   = OP_NONE;
        o_dp_cmd.emit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (t_cmd_code'(i_cmd))
                        CMD_RX: begin
                            priority if (i_status.is_kill) begin
                                if (!i_status.edit_at_commit) begin
                                    o_dp_cmd.op = OP_KILL_START;
                                end
                            end else if (i_status.is_erase) begin
                                if (!i_status.edit_at_commit) begin
                                    o_dp_cmd.op = OP_ERASE;
                                end
                            end else if (!i_status.is_zero && !i_status.full) begin
                                o_dp_cmd.op = OP_STORE;
                            end else begin
                                o_dp_cmd.op = OP_NONE;
                            end
                        end
                        CMD_READ: begin
                            o_dp_cmd.op = i_status.read_at_commit ? OP_EMPTY : OP_READ_ISSUE;
                        end
                        CMD_TX:   o_dp_cmd.op = OP_TX_ECHO;
                        CMD_NONE: o_dp_cmd.op = OP_NONE;
                        default:  o_dp_cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_READ: o_dp_cmd.op = OP_READ_DONE;
            ST_KILL: begin
                o_dp_cmd.op   = kill_cont ? OP_KILL_STEP : OP_KILL_END;
                o_dp_cmd.emit = r_pend;
            end
            default: o_dp_cmd.op = OP_NONE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (o_dp_cmd.op == OP_KILL_START) begin
                    n_state = ST_KILL;
                    n_pend  = 1'b0;
                end else if (o_dp_cmd.op == OP_READ_ISSUE) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_KILL: begin
                if (kill_cont) begin
                    n_pend = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                    n_pend  = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // a read beat that issues a store read waits in ST_READ on the store, then returns to idle
    `CLE_ASSERT_NEXT(a_read_wait, accept && o_dp_cmd.op == OP_READ_ISSUE, r_state == ST_READ, "read did not wait")
    `CLE_ASSERT_NEXT(a_read_back, r_state == ST_READ, r_state == ST_IDLE, "read wait stuck")
    // no kill walk starts over an empty edit region
    `CLE_ASSERT_NOW(a_kill_start, o_dp_cmd.op == OP_KILL_START, !i_status.edit_at_commit, "kill on empty line")

endmodule

/* design/cle_dp.sv */
module cle_dp
    import cle_pkg::*;
#(
    parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data,
    input  t_dp_cmd    i_dp_cmd,
    output t_dp_status o_status,
    output logic       o_strobe,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic       o_line_end,
    output logic       o_last
);

    `include "console_line_editor_assert.svh"

    localparam int PW = $clog2(2 * BUF_DEPTH);
    localparam int SW = $clog2(BUF_DEPTH);
    localparam logic [PW-1:0] DEP_P   = PW'(BUF_DEPTH);
    localparam logic [PW-1:0] SPAN_M1 = PW'(2 * BUF_DEPTH - 1);
    localparam logic [PW:0]   SPAN_W  = (PW+1)'(2 * BUF_DEPTH);

    function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
        pos_next = (p == SPAN_M1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] pos_prev(input logic [PW-1:0] p);
        pos_prev = (p == '0) ? SPAN_M1 : p - 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEP_P) ? p - DEP_P : p;
        slot_of = s[SW-1:0];
    endfunction

    // distance from b forward to a, modulo the position span
    function automatic logic [PW-1:0] pos_dist(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] wrapped;
        wrapped = {1'b0, a} + SPAN_W - {1'b0, b};
        pos_dist = (a >= b) ? a - b : wrapped[PW-1:0];
    endfunction

    logic [7:0]    mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;
    logic [SW-1:0] rd_addr;
    logic [PW-1:0] r_read, r_commit, r_edit;
    logic [PW-1:0] fill;
    logic [PW-1:0] edit_prev;
    logic [PW-1:0] edit_next;
    logic [7:0]    store_char;

    logic          r_strobe;
    t_kind         r_kind;
    logic [7:0]    r_byte;
    logic          r_line_end;
    logic          r_last;
    t_kind         n_kind;
    logic [7:0]    n_byte;
    logic          n_line_end;
    logic          n_last;

    assign fill       = pos_dist(r_edit, r_read);
    assign edit_prev  = pos_prev(r_edit);
    assign edit_next  = pos_next(r_edit);
    assign store_char = (i_data == CH_CR) ? CH_LF : i_data;

    // status toward the controller
    assign o_status.is_kill        = (i_data == CH_KILL);
    assign o_status.is_erase       = (i_data == CH_BS) || (i_data == CH_DEL);
    assign o_status.is_zero        = (i_data == CH_NUL);
    assign o_status.full           = (fill == DEP_P);
    assign o_status.edit_at_commit = (r_edit == r_commit);
    assign o_status.read_at_commit = (r_read == r_commit);
    assign o_status.mem_lf         = (r_rd_data == CH_LF);

    // store read address: reader slot, the char before the edit point, or in a kill step the one before that
    always_comb begin
        unique case (i_dp_cmd.op)
            OP_READ_ISSUE: rd_addr = slot_of(r_read);
            OP_KILL_STEP:  rd_addr = slot_of(pos_prev(edit_prev));
            default:       rd_addr = slot_of(edit_prev);
        endcase
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.op == OP_STORE) begin
            mem[slot_of(r_edit)] <= store_char;
        end
        r_rd_data <= mem[rd_addr];
    end

    // ring positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read   <= '0;
            r_commit <= '0;
            r_edit   <= '0;
        end else begin
            unique case (i_dp_cmd.op)
                OP_STORE: begin
                    r_edit <= edit_next;
                    if (store_char == CH_LF || fill == DEP_P - 1'b1) begin
                        r_commit <= edit_next;
                    end
                end
                OP_ERASE, OP_KILL_STEP: r_edit <= edit_prev;
                OP_READ_DONE:           r_read <= pos_next(r_read);
                default: ;
            endcase
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            unique case (i_dp_cmd.op)
                OP_TX_ECHO, OP_STORE, OP_ERASE, OP_EMPTY, OP_READ_DONE:
                    r_strobe <= 1'b1;
                OP_KILL_STEP, OP_KILL_END:
                    r_strobe <= i_dp_cmd.emit;
                default:
                    r_strobe <= 1'b0;
            endcase
        end
    end

    // next result beat payload
    always_comb begin
        n_kind     = KIND_ERASE;
        n_byte     = '0;
        n_line_end = 1'b0;
        n_last     = 1'b1;
        unique case (i_dp_cmd.op)
            OP_TX_ECHO: begin
                n_kind = KIND_ECHO;
                n_byte = i_data;
            end
            OP_STORE: begin
                n_kind = KIND_ECHO;
                n_byte = store_char;
            end
            OP_EMPTY: n_kind = KIND_EMPTY;
            OP_READ_DONE: begin
                n_kind     = KIND_READ;
                n_byte     = r_rd_data;
                n_line_end = (r_rd_data == CH_LF);
            end
            OP_KILL_STEP: n_last = 1'b0;
            default: ;
        endcase
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_byte     <= n_byte;
        r_line_end <= n_line_end;
        r_last     <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_byte_out = r_byte;
    assign o_line_end = r_line_end;
    assign o_last     = r_last;

    // occupancy never exceeds the ring
    `CLE_ASSERT_NOW(a_fill_bound, 1'b1, fill <= DEP_P, "ring overfilled")
    // committed text lies inside the occupied region
    `CLE_ASSERT_NOW(a_commit_in, 1'b1, pos_dist(r_commit, r_read) <= fill, "commit outside ring")
    // a store always advances the edit point
    `CLE_ASSERT_NEXT(a_store_adv, i_dp_cmd.op == OP_STORE, r_edit == pos_next($past(r_edit)), "store lost")

endmodule

/* design/console_line_editor.sv */
// console line editor over a ring buffer of BUF_DEPTH bytes
//
// input beat: present i_cmd and i_data with start high; the beat is taken at
// the clock edge where start is high and busy is low. i_cmd 0 is a received
// character, 1 reads one committed byte, 2 echoes i_data for transmit.
// results: each result beat is on o_kind, o_byte_out, o_line_end and o_last
// for one cycle while o_strobe is high; o_last marks the final result of the
// input beat. The receiver cannot stall, so results are never held back.
// echo, erase and empty results are registered and appear in the cycle after
// the beat; a committed read passes through the registered store read and
// ST_READ first. Busy stays low after echo, store and erase beats, so one of
// them can be taken every cycle; a read that returns a byte holds busy high
// in ST_READ, an empty read does not. A kill-line walk holds busy and steps
// back one character per cycle through the line store read port, erasing
// up to BUF_DEPTH-1 characters.
// reset (i_rst_n low, synchronous) empties the ring and drops any walk;
// the store contents are not cleared and no clearing pass is needed.
module console_line_editor
    import cle_pkg::*;
#(
    parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data,
    output logic       o_strobe,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic       o_line_end,
    output logic       o_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencing of each beat
    cle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_status (dp_status),
        .o_dp_cmd (dp_cmd),
        .busy     (busy)
    );

    // ring positions, line store and result register
    cle_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_dp_cmd   (dp_cmd),
        .o_status   (dp_status),
        .o_strobe   (o_strobe),
        .o_kind     (o_kind),
        .o_byte_out (o_byte_out),
        .o_line_end (o_line_end),
        .o_last     (o_last)
    );

endmodule

/* test/console_line_editor_tb.sv */
module console_line_editor_tb;
    import cle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W       = $clog2(2 * CLE_BUF_DEPTH);
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BEATS = 40;

    // one result beat as the block should present it
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       line_end;
        logic       last;
    } t_line_result;

    // line discipline predictor plus the queue of results still owed
    class line_discipline_sb;
        logic [7:0]       line_mem [CLE_BUF_DEPTH];
        logic [POS_W-1:0] rd_pos;
        logic [POS_W-1:0] cm_pos;
        logic [POS_W-1:0] ed_pos;
        t_line_result     owed_results [$];
        int               errors;
        int               checked;

        function new();
            rd_pos  = '0;
            cm_pos  = '0;
            ed_pos  = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function int fill_level();
            logic [POS_W-1:0] diff;
            diff = ed_pos - rd_pos;
            return int'(diff);
        endfunction

        function int slot_of(logic [POS_W-1:0] p);
            return int'(p) % CLE_BUF_DEPTH;
        endfunction

        // work out the results of one accepted input beat
        function void note_beat(t_cmd_code cmd, logic [7:0] data);
            t_line_result res [$];
            logic [7:0]   c;
            c = data;
            case (cmd)
                CMD_RX: begin
                    if (c == CH_KILL) begin
                        // kill line walks back over the uncommitted text
                        while (ed_pos != cm_pos && res.size() < CLE_BUF_DEPTH &&
                               line_mem[slot_of(ed_pos - 1'b1)] != CH_LF) begin
                            ed_pos = ed_pos - 1'b1;
                            res.push_back('{kind: KIND_ERASE, data_byte: 8'h00,
                                           line_end: 1'b0, last: 1'b0});
                        end
                    end else if (c == CH_BS || c == CH_DEL) begin
                        if (ed_pos != cm_pos) begin
                            ed_pos = ed_pos - 1'b1;
                            res.push_back('{kind: KIND_ERASE, data_byte: 8'h00,
                                           line_end: 1'b0, last: 1'b0});
                        end
                    end else if (c != CH_NUL && fill_level() < CLE_BUF_DEPTH) begin
                        if (c == CH_CR) begin
                            c = CH_LF;
                        end
                        res.push_back('{kind: KIND_ECHO, data_byte: c,
                                       line_end: 1'b0, last: 1'b0});
                        line_mem[slot_of(ed_pos)] = c;
                        ed_pos = ed_pos + 1'b1;
                        // newline or a full ring commits the line
                        if (c == CH_LF || fill_level() == CLE_BUF_DEPTH) begin
                            cm_pos = ed_pos;
                        end
                    end
                end
                CMD_READ: begin
                    if (rd_pos == cm_pos) begin
                        res.push_back('{kind: KIND_EMPTY, data_byte: 8'h00,
                                       line_end: 1'b0, last: 1'b0});
                    end else begin
                        c = line_mem[slot_of(rd_pos)];
                        rd_pos = rd_pos + 1'b1;
                        res.push_back('{kind: KIND_READ, data_byte: c,
                                       line_end: (c == CH_LF), last: 1'b0});
                    end
                end
                CMD_TX: begin
                    res.push_back('{kind: KIND_ECHO, data_byte: data,
                                   line_end: 1'b0, last: 1'b0});
                end
                default: begin
                end
            endcase
            if (res.size() > 0) begin
                res[res.size() - 1].last = 1'b1;
            end
            foreach (res[i]) begin
                owed_results.push_back(res[i]);
            end
        endfunction

        function void field_check(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one result beat against the oldest owed result
        function void check_result(t_kind kind, logic [7:0] data_byte,
                                   logic line_end, logic last);
            t_line_result want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual kind %0d byte %0h",
                         $time, kind, data_byte);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            field_check("kind", want.kind, kind);
            field_check("byte_out", want.data_byte, data_byte);
            field_check("line_end", want.line_end, line_end);
            field_check("last", want.last, last);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_cmd;
    logic [7:0] i_data;
    logic       o_strobe;
    logic [1:0] o_kind;
    logic [7:0] o_byte_out;
    logic       o_line_end;
    logic       o_last;

    line_discipline_sb sb;
    int                sender_idle_pct;
    int                beats_sent;
    int                cycle_count;
    int                floods;

    console_line_editor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_data     (i_data),
        .o_strobe   (o_strobe),
        .o_kind     (o_kind),
        .o_byte_out (o_byte_out),
        .o_line_end (o_line_end),
        .o_last     (o_last)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result monitor, results cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(t_kind'(o_kind), o_byte_out, o_line_end, o_last);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still owed", $time,
                     sb.owed_results.size());
            $display("console_line_editor_tb: FAIL");
            $finish;
        end
    end

    // drive one input beat, entered and left at a falling edge
    task automatic send_beat(input t_cmd_code cmd, input logic [7:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_cmd  = cmd;
        i_data = data;
        do @(posedge i_clk); while (busy);
        sb.note_beat(cmd, data);
        if (cmd != CMD_NONE) begin
            beats_sent++;
        end
        @(negedge i_clk);
    endtask

    // nonzero character that is stored as text, low and high bytes alike
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do begin
            c = ($urandom_range(3) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(1, 126));
        end while (c == CH_KILL || c == CH_BS || c == CH_DEL || c == CH_CR ||
                   c == CH_LF);
        return c;
    endfunction

    // type until the ring is nearly full, kill the line, refill and overflow
    task automatic flood_ring();
        floods++;
        while (sb.fill_level() < CLE_BUF_DEPTH - 1) begin
            send_beat(CMD_RX, text_char());
        end
        send_beat(CMD_RX, CH_KILL);
        while (sb.fill_level() < CLE_BUF_DEPTH) begin
            send_beat(CMD_RX, text_char());
        end
        send_beat(CMD_RX, text_char());
        send_beat(CMD_RX, CH_CR);
        send_beat(CMD_RX, CH_BS);
        send_beat(CMD_RX, CH_KILL);
    endtask

    initial begin
        int phase_end;
        int seq_no;
        int pick;
        int len;

        sb              = new();
        sender_idle_pct = 0;
        beats_sent      = 0;
        cycle_count     = 0;
        floods          = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = CMD_RX;
        i_data          = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty ring, nothing to erase, dropped and ignored beats
        send_beat(CMD_READ, 8'hff);
        send_beat(CMD_RX, CH_BS);
        send_beat(CMD_RX, CH_DEL);
        send_beat(CMD_RX, CH_KILL);
        send_beat(CMD_RX, CH_NUL);
        send_beat(CMD_NONE, 8'hff);
        send_beat(CMD_TX, 8'h00);
        send_beat(CMD_TX, 8'hff);
        // directed: edit a line, commit on carriage return, kill a partial line
        send_beat(CMD_RX, 8'h61);
        send_beat(CMD_RX, 8'h62);
        send_beat(CMD_RX, CH_BS);
        send_beat(CMD_RX, CH_DEL);
        send_beat(CMD_RX, 8'h63);
        send_beat(CMD_RX, 8'hff);
        send_beat(CMD_RX, CH_CR);
        send_beat(CMD_RX, 8'h78);
        send_beat(CMD_RX, 8'h79);
        send_beat(CMD_RX, CH_KILL);
        repeat (4) send_beat(CMD_READ, 8'h00);

        // random: three pacing phases of mostly well-formed line traffic
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 73 : 0;
            phase_end = beats_sent + PHASE_BEATS;
            seq_no = 0;
            while (beats_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick >= 98 || (phase == 1 && seq_no == 5)) begin
                    flood_ring();
                end else if (pick < 35) begin
                    // typed line with occasional erases
                    len = $urandom_range(0, 10);
                    repeat (len) begin
                        if ($urandom_range(99) < 12) begin
                            send_beat(CMD_RX, $urandom_range(1) ? CH_BS : CH_DEL);
                        end else begin
                            send_beat(CMD_RX, text_char());
                        end
                    end
                    if ($urandom_range(9) != 0) begin
                        send_beat(CMD_RX, $urandom_range(1) ? CH_CR : CH_LF);
                    end
                end else if (pick < 50) begin
                    // partial line then kill
                    len = $urandom_range(1, 12);
                    repeat (len) send_beat(CMD_RX, text_char());
                    send_beat(CMD_RX, CH_KILL);
                end else if (pick < 75) begin
                    repeat ($urandom_range(1, 8)) send_beat(CMD_READ, 8'($urandom_range(255)));
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 3)) send_beat(CMD_TX, 8'($urandom_range(255)));
                end else begin
                    // noise beat, any command and any byte
                    send_beat(t_cmd_code'($urandom_range(3)), 8'($urandom_range(255)));
                end
                seq_no++;
            end
        end

        start = 1'b0;

        // drain owed results, then watch for stray ones
        while (sb.owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (CLE_BUF_DEPTH + 8) @(posedge i_clk);

        $display("covered %0d command beats and %0d result beats over three pacing phases,",
                 beats_sent, sb.checked);
        $display("with %0d ring floods, kill-line walks, erases, reads and echoes", floods);
        if (sb.errors == 0) begin
            $display("console_line_editor_tb: PASS");
        end else begin
            $display("console_line_editor_tb: FAIL");
        end
        $finish;
    end

endmodule
